FILE: design/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, codes and sizes of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
    localparam logic [31:0] PAGE_LEN  = 32'(PAGE_BYTES);

    // request kinds
    localparam logic [1:0] OP_ALLOC_FIRST = 2'd0;
    localparam logic [1:0] OP_ALLOC_AT    = 2'd1;
    localparam logic [1:0] OP_LOOKUP      = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NULL_ADDR = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] req_address;
        logic [31:0] req_size;
    } ffra_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic        region_is_free;
    } ffra_out_t;

    // one table write: update entry w, optionally insert a free entry at w+1
    typedef struct packed {
        logic [IDX_W-1:0] w;
        logic [31:0]      w_len;
        logic             w_free;
        logic             ins;
        logic [31:0]      ins_base;
        logic [31:0]      ins_len;
    } ffra_step_t;

    typedef enum logic [1:0] {
        SRC_CHECK,
        SRC_NOT_FOUND,
        SRC_DECIDE
    } ffra_src_t;

    typedef struct packed {
        logic      req_load;
        logic      scan_clr;
        logic      scan_inc;
        logic      hit_cap;
        logic      res_wr;
        ffra_src_t res_src;
        logic      plan_cap;
        logic      step_en;
        logic      step_sel;
        logic      out_load;
    } ffra_cmd_t;

    typedef struct packed {
        logic chk_err;
        logic scan_hit;
        logic scan_end;
        logic any_step;
        logic two_steps;
        logic out_free;
    } ffra_sts_t;

endpackage

FILE: design/first_fit_region_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_unit
// First-fit region allocator: allocate, allocate at address, lookup.
// ----------------------------------------------------------------------------
// One request is worked at a time: a parameter check, a scan of the table
// entries up to the hit (at most 16), a decision and up to two table
// writes; the entry scan runs one entry per cycle. The next request is
// taken while the previous result waits in the output register.
// Writing pool_base or pool_size reinitialises the table to one free region.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_unit import ffra_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ffra_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ffra_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    ffra_cmd_t cmd;
    ffra_sts_t sts;

    assign cfg_ready = 1'b1;

    ffra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffra_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: design/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: check, scan, decide, apply table writes, hand over the result.
// ----------------------------------------------------------------------------
module ffra_ctrl import ffra_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffra_sts_t sts,
    output ffra_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_STEP1,
        S_STEP2,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // issue commands and pick the next state
    always_comb begin
        cmd        = '0;
        cmd.res_src = SRC_CHECK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_clr = 1'b1;
                if (sts.chk_err) begin
                    cmd.res_wr = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_end) begin
                    cmd.res_wr  = 1'b1;
                    cmd.res_src = SRC_NOT_FOUND;
                    state_next  = S_DONE;
                end else if (sts.scan_hit) begin
                    cmd.hit_cap = 1'b1;
                    state_next  = S_DECIDE;
                end else begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_DECIDE: begin
                cmd.res_wr   = 1'b1;
                cmd.res_src  = SRC_DECIDE;
                cmd.plan_cap = 1'b1;
                state_next   = sts.any_step ? S_STEP1 : S_DONE;
            end
            S_STEP1: begin
                cmd.step_en = 1'b1;
                state_next  = sts.two_steps ? S_STEP2 : S_DONE;
            end
            S_STEP2: begin
                cmd.step_en  = 1'b1;
                cmd.step_sel = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ffra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_datapath
// Region table, request and hit registers, decision logic and output beat.
// ----------------------------------------------------------------------------
module ffra_datapath import ffra_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffra_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ffra_out_t            m_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  ffra_cmd_t            cmd,
    output ffra_sts_t            sts
);

    logic [31:0]      pool_base_reg, pool_size_reg;
    logic [31:0]      entry_base_reg [MAX_REGIONS];
    logic [31:0]      entry_length_reg [MAX_REGIONS];
    logic             entry_free_reg [MAX_REGIONS];
    logic [CNT_W-1:0] entry_count_reg;

    ffra_in_t         req_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_base_reg, hit_len_reg;
    logic             hit_free_reg;
    ffra_step_t       step0_reg, step1_reg;
    logic             two_reg;
    ffra_out_t        res_reg;
    logic             m_valid_reg;
    ffra_out_t        m_data_reg;

    // read the entry under the scan pointer and test it
    logic [31:0] cur_base, cur_len;
    logic        cur_free;
    logic [32:0] cur_end;
    assign cur_base = entry_base_reg[scan_reg[IDX_W-1:0]];
    assign cur_len  = entry_length_reg[scan_reg[IDX_W-1:0]];
    assign cur_free = entry_free_reg[scan_reg[IDX_W-1:0]];
    assign cur_end  = {1'b0, cur_base} + {1'b0, cur_len};

    always_comb begin
        if (req_reg.op == OP_ALLOC_FIRST) begin
            sts.scan_hit = cur_free && (cur_len >= req_reg.req_size);
        end else begin
            sts.scan_hit = (req_reg.req_address >= cur_base) &&
                           ({1'b0, req_reg.req_address} < cur_end);
        end
    end
    assign sts.scan_end = (scan_reg == entry_count_reg);

    // parameter checks ahead of the scan
    logic [2:0] chk_status;
    always_comb begin
        chk_status = ST_OK;
        case (req_reg.op)
            OP_ALLOC_FIRST: begin
                if (req_reg.req_size == 32'd0) chk_status = ST_INVALID;
            end
            OP_ALLOC_AT: begin
                if (req_reg.req_address == 32'd0)   chk_status = ST_NULL_ADDR;
                else if (req_reg.req_size == 32'd0) chk_status = ST_INVALID;
            end
            OP_LOOKUP: begin
                if (req_reg.req_address == 32'd0) chk_status = ST_NULL_ADDR;
            end
            default: chk_status = ST_INVALID;
        endcase
    end
    assign sts.chk_err = (chk_status != ST_OK);

    // work out the outcome of a hit and the table writes it needs
    logic [32:0]      rsum;
    logic [31:0]      rnd, inner, slack, hit_end_lo;
    logic             need1, mid, need2;
    logic [CNT_W:0]   cnt_ext;
    ffra_out_t        dec_res;
    ffra_step_t       dec_s0, dec_s1;
    logic [1:0]       dec_steps;
    logic [IDX_W-1:0] h1;

    always_comb begin
        rsum       = {1'b0, req_reg.req_size} + {1'b0, PAGE_MASK};
        rnd        = rsum[31:0] & ~PAGE_MASK;
        hit_end_lo = hit_base_reg + hit_len_reg;
        inner      = hit_end_lo - req_reg.req_address;
        slack      = hit_len_reg - req_reg.req_size;
        need1      = slack > PAGE_LEN;
        mid        = hit_base_reg != req_reg.req_address;
        need2      = mid && ((inner - req_reg.req_size) > PAGE_LEN);
        cnt_ext    = {1'b0, entry_count_reg};
        h1         = hit_idx_reg + IDX_W'(1);
        dec_res    = '0;
        dec_s0     = '0;
        dec_s1     = '0;
        dec_steps  = 2'd0;
        dec_s0.w   = hit_idx_reg;
        case (req_reg.op)
            OP_ALLOC_FIRST: begin
                if (cnt_ext + (CNT_W+1)'(need1) > (CNT_W+1)'(MAX_REGIONS)) begin
                    dec_res.status = ST_FULL;
                end else begin
                    dec_steps          = 2'd1;
                    dec_s0.w_len       = need1 ? rnd : hit_len_reg;
                    dec_s0.ins         = need1;
                    dec_s0.ins_base    = hit_base_reg + rnd;
                    dec_s0.ins_len     = hit_len_reg - rnd;
                    dec_res.region_base = hit_base_reg;
                    dec_res.region_size = need1 ? rnd : hit_len_reg;
                end
            end
            OP_ALLOC_AT: begin
                if (!hit_free_reg || inner < req_reg.req_size) begin
                    dec_res.status = ST_NOT_FOUND;
                end else if (!(mid || need1)) begin
                    dec_steps           = 2'd1;
                    dec_s0.w_len        = hit_len_reg;
                    dec_res.region_base = hit_base_reg;
                    dec_res.region_size = hit_len_reg;
                end else if (slack < PAGE_LEN) begin
                    dec_res.status = ST_INVALID;
                end else if (cnt_ext + (need2 ? (CNT_W+1)'(2) : (CNT_W+1)'(1)) >
                             (CNT_W+1)'(MAX_REGIONS)) begin
                    dec_res.status = ST_FULL;
                end else if (mid) begin
                    dec_steps           = 2'd2;
                    dec_s0.w_len        = req_reg.req_address - hit_base_reg;
                    dec_s0.w_free       = 1'b1;
                    dec_s0.ins          = 1'b1;
                    dec_s0.ins_base     = req_reg.req_address;
                    dec_s0.ins_len      = inner;
                    dec_s1.w            = h1;
                    dec_s1.w_len        = need2 ? rnd : inner;
                    dec_s1.ins          = need2;
                    dec_s1.ins_base     = req_reg.req_address + rnd;
                    dec_s1.ins_len      = inner - rnd;
                    dec_res.region_base = req_reg.req_address;
                    dec_res.region_size = need2 ? rnd : inner;
                end else begin
                    dec_steps           = 2'd1;
                    dec_s0.w_len        = rnd;
                    dec_s0.ins          = 1'b1;
                    dec_s0.ins_base     = hit_base_reg + rnd;
                    dec_s0.ins_len      = hit_len_reg - rnd;
                    dec_res.region_base = hit_base_reg;
                    dec_res.region_size = rnd;
                end
            end
            default: begin
                dec_res.region_base    = hit_base_reg;
                dec_res.region_size    = hit_len_reg;
                dec_res.region_is_free = hit_free_reg;
            end
        endcase
    end
    assign sts.any_step  = (dec_steps != 2'd0);
    assign sts.two_steps = two_reg;

    // hold request, scan pointer, hit, plan and result
    always_ff @(posedge aclk) begin
        if (cmd.req_load) req_reg <= s_data;
        if (cmd.scan_clr) scan_reg <= '0;
        else if (cmd.scan_inc) scan_reg <= scan_reg + CNT_W'(1);
        if (cmd.hit_cap) begin
            hit_idx_reg  <= scan_reg[IDX_W-1:0];
            hit_base_reg <= cur_base;
            hit_len_reg  <= cur_len;
            hit_free_reg <= cur_free;
        end
        if (cmd.plan_cap) begin
            step0_reg <= dec_s0;
            step1_reg <= dec_s1;
            two_reg   <= (dec_steps == 2'd2);
        end
        if (cmd.res_wr) begin
            case (cmd.res_src)
                SRC_CHECK:     res_reg <= '{chk_status, 32'd0, 32'd0, 1'b0};
                SRC_NOT_FOUND: res_reg <= '{ST_NOT_FOUND, 32'd0, 32'd0, 1'b0};
                default:       res_reg <= dec_res;
            endcase
        end
    end

    // apply a table write, or reinitialise on a configuration beat
    ffra_step_t       stp;
    logic [IDX_W:0]   pos;
    logic [32:0]      init_end;
    logic [31:0]      new_base, new_size;
    assign stp      = cmd.step_sel ? step1_reg : step0_reg;
    assign pos      = {1'b0, stp.w} + (IDX_W+1)'(1);
    assign new_base = (cfg_index == CFG_POOL_BASE) ? cfg_data : pool_base_reg;
    assign new_size = (cfg_index == CFG_POOL_SIZE) ? cfg_data : pool_size_reg;
    assign init_end = {1'b0, new_base} + {1'b0, new_size};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= 32'd4096;
            pool_size_reg   <= 32'd1048576;
            entry_count_reg <= CNT_W'(1);
            for (int k = 1; k < MAX_REGIONS; k++) begin
                entry_base_reg[k]   <= '0;
                entry_length_reg[k] <= '0;
                entry_free_reg[k]   <= 1'b0;
            end
            entry_base_reg[0]   <= 32'd4096;
            entry_length_reg[0] <= 32'd1048576;
            entry_free_reg[0]   <= 1'b1;
        end else if (cfg_valid && (cfg_index == CFG_POOL_BASE ||
                                   cfg_index == CFG_POOL_SIZE)) begin
            pool_base_reg       <= new_base;
            pool_size_reg       <= new_size;
            entry_count_reg     <= CNT_W'(1);
            entry_base_reg[0]   <= new_base;
            entry_length_reg[0] <= init_end[32] ? (32'd0 - new_base) : new_size;
            entry_free_reg[0]   <= 1'b1;
        end else if (cmd.step_en) begin
            if (stp.ins) begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
                for (int k = 1; k < MAX_REGIONS; k++) begin
                    if ((IDX_W+1)'(k) > pos) begin
                        entry_base_reg[k]   <= entry_base_reg[k-1];
                        entry_length_reg[k] <= entry_length_reg[k-1];
                        entry_free_reg[k]   <= entry_free_reg[k-1];
                    end else if ((IDX_W+1)'(k) == pos) begin
                        entry_base_reg[k]   <= stp.ins_base;
                        entry_length_reg[k] <= stp.ins_len;
                        entry_free_reg[k]   <= 1'b1;
                    end
                end
            end
            entry_length_reg[stp.w] <= stp.w_len;
            entry_free_reg[stp.w]   <= stp.w_free;
        end
    end

    // output beat register
    assign sts.out_free = !m_valid_reg || m_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) m_data_reg <= res_reg;
    end
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // table never empties nor overflows
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg != '0 && entry_count_reg <= CNT_W'(MAX_REGIONS))
        else $error("entry count out of range");

    // an insertion only happens with a spare entry
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_en && stp.ins |-> entry_count_reg < CNT_W'(MAX_REGIONS))
        else $error("insertion into full table");

    // a delivered status is a defined code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.status <= ST_FULL)
        else $error("undefined status code");

endmodule
